// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the UTF-8 stream decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define U8D_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle outside reset.
`define U8D_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/u8d_pkg.sv =====
// Types and constants shared by the UTF-8 stream decoder modules.
package u8d_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned BytesWidth = 3;

  localparam logic [CpWidth-1:0] SurrLo = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrHi = 21'h00DFFF;
  localparam logic [CpWidth-1:0] CpMax  = 21'h10FFFF;

  localparam logic [BytesWidth-1:0] Len1 = 3'd1;
  localparam logic [BytesWidth-1:0] Len2 = 3'd2;
  localparam logic [BytesWidth-1:0] Len3 = 3'd3;
  localparam logic [BytesWidth-1:0] Len4 = 3'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEAD  = 2'd1,
    ST_SURROGATE = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]            pending;
    logic [CpWidth-1:0]    accum;
    logic [BytesWidth-1:0] total;
  } seq_state_t;

  typedef struct packed {
    logic                  valid;
    logic [CpWidth-1:0]    code_point;
    logic [BytesWidth-1:0] seq_bytes;
    status_e               status;
  } dec_result_t;

endpackage

// ===== hw/rtl/u8d_step.sv =====
// Next-state and result logic for one byte of the UTF-8 stream.
module u8d_step import u8d_pkg::*; (
  input  seq_state_t  state_i,
  input  logic [7:0]  byte_i,
  output seq_state_t  state_o,
  output dec_result_t result_o
);

  logic [CpWidth-1:0] acc_next;
  logic [1:0]         pend_next;

  assign acc_next  = {state_i.accum[CpWidth-7:0], byte_i[5:0]};
  assign pend_next = state_i.pending - 2'd1;

  always_comb begin
    state_o  = state_i;
    result_o = '{valid: 1'b0, code_point: '0, seq_bytes: Len1, status: ST_OK};
    if (state_i.pending != 2'd0) begin
      if (pend_next != 2'd0) begin
        state_o.accum   = acc_next;
        state_o.pending = pend_next;
      end else begin
        state_o        = '0;
        result_o.valid = 1'b1;
        result_o.seq_bytes = state_i.total;
        if (state_i.total == Len3 && acc_next >= SurrLo && acc_next <= SurrHi) begin
          result_o.status = ST_SURROGATE;
        end else if (state_i.total == Len4 && acc_next > CpMax) begin
          result_o.status = ST_TOO_LARGE;
        end else begin
          result_o.code_point = acc_next;
        end
      end
    end else begin
      unique case (byte_i[7:3]) inside
        [5'b00000:5'b01111]: begin
          result_o.valid      = 1'b1;
          result_o.code_point = {{(CpWidth-8){1'b0}}, byte_i};
        end
        [5'b11000:5'b11011]: begin
          state_o.accum   = {{(CpWidth-5){1'b0}}, byte_i[4:0]};
          state_o.pending = 2'd1;
          state_o.total   = Len2;
        end
        [5'b11100:5'b11101]: begin
          state_o.accum   = {{(CpWidth-4){1'b0}}, byte_i[3:0]};
          state_o.pending = 2'd2;
          state_o.total   = Len3;
        end
        5'b11110: begin
          state_o.accum   = {{(CpWidth-3){1'b0}}, byte_i[2:0]};
          state_o.pending = 2'd3;
          state_o.total   = Len4;
        end
        default: begin
          result_o.valid  = 1'b1;
          result_o.status = ST_BAD_LEAD;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder: input register, decode step and result register.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o   data_byte_i[7:0]
//   out      output     out_valid_o/out_stall_i code_point_o[20:0], seq_bytes_o[2:0], status_o[1:0]
//
// One byte is accepted per cycle while in_stall_o is low; out_valid_o marks a registered result.
// The decode step sits between the input register and the result register.
// Reset clears the open sequence and both valid flags.
// A stalled result holds the input register only while its byte yields a result.
// Such a stall reaches in_stall_o within the same cycle.
`include "assert_macros.svh"

module utf8_stream_decoder_top import u8d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CpWidth-1:0]    code_point_o,
  output logic [BytesWidth-1:0] seq_bytes_o,
  output logic [1:0]            status_o
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  byte_q;
  seq_state_t  state_q, state_d;
  dec_result_t res;
  logic        out_valid_q, out_valid_d;
  logic [CpWidth-1:0]    cp_q;
  logic [BytesWidth-1:0] bytes_q;
  status_e     status_q;
  logic        out_free;
  logic        advance;
  logic        in_accept;

  u8d_step u_step (
    .state_i  (state_q),
    .byte_i   (byte_q),
    .state_o  (state_d),
    .result_o (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!res.valid || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && res.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
    end
    if (advance && res.valid) begin
      cp_q     <= res.code_point;
      bytes_q  <= res.seq_bytes;
      status_q <= res.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign seq_bytes_o  = bytes_q;
  assign status_o     = status_q;

  `U8D_ASSERT_IMPL(a_err_zero_cp, clk_i, rst_ni, out_valid_o && status_q != ST_OK,
    code_point_o == '0, "Error result carries a nonzero code point.")
  `U8D_ASSERT_IMPL(a_err_len, clk_i, rst_ni, out_valid_o && status_q == ST_SURROGATE,
    seq_bytes_o == Len3, "Surrogate result does not span three bytes.")
  `U8D_ASSERT_IMPL(a_stall_src, clk_i, rst_ni, in_stall_o,
    in_valid_q && out_valid_q && out_stall_i, "Input stalled without a blocked result.")
  `U8D_ASSERT(a_open_seq, clk_i, rst_ni,
    state_q.pending == 2'd0 || state_q.total > {1'b0, state_q.pending},
    "Open sequence length is inconsistent with the pending count.")

endmodule

// ===== tb/tb_utf8_stream_decoder_top.sv =====
// Self-checking testbench for the UTF-8 stream decoder top level.
module tb_utf8_stream_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8d_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned PhaseBytes    = 300;
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned TailCycles    = 16;

  typedef struct {
    logic [CpWidth-1:0]    code_point;
    logic [BytesWidth-1:0] seq_bytes;
    status_e               status;
  } decoded_t;

  class utf8_scoreboard;
    logic [1:0]            cont_left;
    logic [CpWidth-1:0]    acc_bits;
    logic [BytesWidth-1:0] open_len;
    decoded_t              decoded_q[$];
    int                    mismatches;
    int                    bytes_seen;
    int                    results_seen;
    int                    status_count[4];

    function new();
      cont_left  = '0;
      acc_bits   = '0;
      open_len   = '0;
      mismatches = 0;
      bytes_seen = 0;
      results_seen = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void push_decoded(logic [CpWidth-1:0] cp, logic [BytesWidth-1:0] len,
                               status_e st);
      decoded_t d;
      d.code_point = cp;
      d.seq_bytes  = len;
      d.status     = st;
      decoded_q.push_back(d);
    endfunction

    function void decode_byte(logic [7:0] b);
      logic [CpWidth-1:0]    cp;
      logic [BytesWidth-1:0] len;
      bytes_seen++;
      if (cont_left != 2'd0) begin
        acc_bits  = {acc_bits[CpWidth-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left != 2'd0) return;
        cp       = acc_bits;
        len      = open_len;
        acc_bits = '0;
        open_len = '0;
        if (len == Len3 && cp >= SurrLo && cp <= SurrHi) begin
          push_decoded('0, Len3, ST_SURROGATE);
        end else if (len == Len4 && cp > CpMax) begin
          push_decoded('0, Len4, ST_TOO_LARGE);
        end else begin
          push_decoded(cp, len, ST_OK);
        end
      end else if (b < 8'h80) begin
        push_decoded(CpWidth'(b), Len1, ST_OK);
      end else if (b < 8'hC0) begin
        push_decoded('0, Len1, ST_BAD_LEAD);
      end else if (b < 8'hE0) begin
        acc_bits  = CpWidth'(b[4:0]);
        cont_left = 2'd1;
        open_len  = Len2;
      end else if (b < 8'hF0) begin
        acc_bits  = CpWidth'(b[3:0]);
        cont_left = 2'd2;
        open_len  = Len3;
      end else if (b < 8'hF8) begin
        acc_bits  = CpWidth'(b[2:0]);
        cont_left = 2'd3;
        open_len  = Len4;
      end else begin
        push_decoded('0, Len1, ST_BAD_LEAD);
      end
    endfunction

    function void check_decoded(logic [CpWidth-1:0] cp, logic [BytesWidth-1:0] len,
                                logic [1:0] st);
      decoded_t d;
      results_seen++;
      status_count[st]++;
      if (decoded_q.size() == 0) begin
        $error("Unexpected result: code_point %h seq_bytes %0d status %0d", cp, len, st);
        mismatches++;
        return;
      end
      d = decoded_q.pop_front();
      if (cp !== d.code_point) begin
        $error("code_point: expected %h, actual %h", d.code_point, cp);
        mismatches++;
      end
      if (len !== d.seq_bytes) begin
        $error("seq_bytes: expected %0d, actual %0d", d.seq_bytes, len);
        mismatches++;
      end
      if (st !== d.status) begin
        $error("status: expected %0d, actual %0d", d.status, st);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return decoded_q.size();
    endfunction
  endclass

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i  = 8'h00;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [CpWidth-1:0]    code_point_o;
  logic [BytesWidth-1:0] seq_bytes_o;
  logic [1:0]            status_o;

  utf8_scoreboard sb;
  logic [7:0]     burst_q[$];
  bit             tx_quiet  = 1'b0;
  bit             rx_quiet  = 1'b0;
  bit             hold_req  = 1'b0;
  bit             hold_done = 1'b0;
  int             idle_cycles = 0;

  utf8_stream_decoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .seq_bytes_o  (seq_bytes_o),
    .status_o     (status_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int idle_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic void build_burst();
    int kind;
    int n;
    burst_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      burst_q.push_back(8'($urandom));
    end else if (kind < 25) begin
      n = $urandom_range(2, 4);
      burst_q.push_back({5'b11110, 3'($urandom)} >> (4 - n));
      burst_q[0] = (n == 2) ? {3'b110, 5'($urandom)} :
                   (n == 3) ? {4'b1110, 4'($urandom)} : {5'b11110, 3'($urandom)};
      repeat ($urandom_range(0, n - 2)) burst_q.push_back(cont_byte());
    end else begin
      n = $urandom_range(1, 4);
      case (n)
        1: burst_q.push_back({1'b0, 7'($urandom)});
        2: burst_q.push_back({3'b110, 5'($urandom)});
        3: burst_q.push_back(($urandom_range(0, 3) == 0) ? 8'hED : {4'b1110, 4'($urandom)});
        default: begin
          burst_q.push_back(($urandom_range(0, 2) == 0) ? 8'hF4 : {5'b11110, 3'($urandom)});
        end
      endcase
      repeat (n - 1) burst_q.push_back(cont_byte());
    end
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = idle_len(tx_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.decode_byte(data_byte_i);
      if (out_valid_o && !out_stall_i) sb.check_decoded(code_point_o, seq_bytes_o, status_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired with %0d results outstanding.", sb.outstanding());
        $display("tb_utf8_stream_decoder_top: FAIL");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin : receiver
    logic lvl;
    int   len;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_done = 1'b1;
        lvl = 1'b1;
        len = HoldCycles;
      end else if (rx_quiet) begin
        lvl = 1'b0;
        len = 1;
      end else if ($urandom_range(0, 99) < 30) begin
        lvl = 1'b1;
        len = idle_len(1'b0) + 1;
      end else begin
        lvl = 1'b0;
        len = $urandom_range(1, 8);
      end
      out_stall_i <= lvl;
      repeat (len) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    logic [7:0] directed[] = '{
      8'h00, 8'h7F, 8'hBF, 8'hFF,
      8'hC0, 8'h80,
      8'hDF, 8'h3F,
      8'hED, 8'hA0, 8'h80,
      8'hED, 8'hBF, 8'hBF,
      8'hF4, 8'h8F, 8'hBF, 8'hBF,
      8'hF4, 8'h90, 8'h80, 8'h80,
      8'hE2, 8'h82, 8'hAC
    };
    int sent;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send_byte(directed[i]);
    for (int ph = 0; ph < NumPhases; ph++) begin
      tx_quiet = (ph == 1) || (ph == 3);
      rx_quiet = (ph == 1);
      if (ph == 1) hold_req = 1'b1;
      sent = 0;
      while (sent < PhaseBytes) begin
        build_burst();
        foreach (burst_q[i]) send_byte(burst_q[i]);
        sent += burst_q.size();
      end
      if (ph == 1) drain();
    end
    drain();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d bytes; checked %0d results (%0d ok, %0d bad lead, %0d surrogate,",
             sb.bytes_seen, sb.results_seen, sb.status_count[ST_OK],
             sb.status_count[ST_BAD_LEAD], sb.status_count[ST_SURROGATE]);
    $display("%0d too large), with random idling, one long output hold and one drain pause.",
             sb.status_count[ST_TOO_LARGE]);
    if (sb.mismatches == 0 && sb.outstanding() == 0 && hold_done) begin
      $display("tb_utf8_stream_decoder_top: PASS");
    end else begin
      if (sb.outstanding() != 0) $error("%0d expected results never arrived", sb.outstanding());
      $display("tb_utf8_stream_decoder_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_step.sv
hw/rtl/utf8_stream_decoder_top.sv
tb/tb_utf8_stream_decoder_top.sv
